### hdl/base64_stream_encoder_defines.svh
// assertion macros for the base64 stream encoder
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define B64E_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("assertion failed");
`define B64E_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("assertion failed");
`else
`define B64E_ASSERT(lbl, expr)
`define B64E_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/b64e_pkg.sv
// types, constants and the sextet to ascii mapping for the base64 stream encoder
package b64e_pkg;

  localparam logic [7:0] CharUpperA = 8'd65;
  localparam logic [7:0] CharLowerA = 8'd97;
  localparam logic [7:0] CharZero   = 8'd48;
  localparam logic [7:0] CharPlus   = 8'd43;
  localparam logic [7:0] CharSlash  = 8'd47;
  localparam logic [7:0] CharPad    = 8'd61;

  typedef enum logic [1:0] {
    PHASE_FIRST  = 2'd0,
    PHASE_SECOND = 2'd1,
    PHASE_THIRD  = 2'd2
  } phase_t;

  typedef struct packed {
    logic       pad;
    logic [5:0] val;
  } sym_t;

  typedef struct packed {
    sym_t [3:0] sym;
    logic [1:0] last_idx;
    logic       last;
  } job_t;

  typedef struct packed {
    logic       busy;
    logic [1:0] idx;
    logic [1:0] last_idx;
  } back_stat_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] r;
    r = CharSlash;
    if (v < 6'd26) begin
      r = CharUpperA + {2'b00, v};
    end else if (v < 6'd52) begin
      r = CharLowerA + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = CharZero + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = CharPlus;
    end
    return r;
  endfunction

  function automatic logic [7:0] sym_char(input sym_t s);
    return s.pad ? CharPad : sextet_char(s.val);
  endfunction

endpackage

### hdl/b64e_front.sv
// front end: takes bytes, tracks group phase and builds a character job
module b64e_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic             q_full,
  output logic             push,
  output b64e_pkg::job_t   job
);

  b64e_pkg::phase_t phase, phase_next;
  logic [3:0]       leftover, leftover_next;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    job           = '0;
    phase_next    = b64e_pkg::PHASE_FIRST;
    leftover_next = 4'd0;
    job.last      = last_byte;
    case (phase)
      b64e_pkg::PHASE_SECOND: begin
        job.sym[0].val = {leftover[1:0], data_byte[7:4]};
        if (last_byte) begin
          job.sym[1].val = {data_byte[3:0], 2'b00};
          job.sym[2].pad = 1'b1;
          job.last_idx   = 2'd2;
        end else begin
          job.last_idx  = 2'd0;
          phase_next    = b64e_pkg::PHASE_THIRD;
          leftover_next = data_byte[3:0];
        end
      end
      b64e_pkg::PHASE_THIRD: begin
        job.sym[0].val = {leftover, data_byte[7:6]};
        job.sym[1].val = data_byte[5:0];
        job.last_idx   = 2'd1;
      end
      default: begin
        job.sym[0].val = data_byte[7:2];
        if (last_byte) begin
          job.sym[1].val = {data_byte[1:0], 4'b0000};
          job.sym[2].pad = 1'b1;
          job.sym[3].pad = 1'b1;
          job.last_idx   = 2'd3;
        end else begin
          job.last_idx  = 2'd0;
          phase_next    = b64e_pkg::PHASE_SECOND;
          leftover_next = {2'b00, data_byte[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= b64e_pkg::PHASE_FIRST;
      leftover <= 4'd0;
    end else if (push) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

### hdl/b64e_queue.sv
// small job queue between the front and back ends
module b64e_queue #(
  parameter int Depth = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  b64e_pkg::job_t             push_job,
  input  logic                       pop,
  output b64e_pkg::job_t             head,
  output logic                       nonempty,
  output logic                       full,
  output logic [$clog2(Depth+1)-1:0] count
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  b64e_pkg::job_t mem [Depth];
  logic [PtrW-1:0] wptr, rptr;
  logic            do_push, do_pop;

  assign nonempty = (count != '0);
  assign full     = (count == CntW'(Depth));
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/b64e_back.sv
// back end: walks a job one character per cycle into the output register while the output is not stalled
module b64e_back (
  input  logic                 clk,
  input  logic                 rst,
  input  b64e_pkg::job_t       head,
  input  logic                 q_nonempty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_char,
  output logic                 out_last,
  output b64e_pkg::back_stat_t stat
);

  b64e_pkg::job_t job;
  logic           busy;
  logic [1:0]     idx;
  logic           advance, finish;

  assign advance = busy && (!out_valid || !out_stall);
  assign finish  = advance && (idx == job.last_idx);
  assign pop     = q_nonempty && (!busy || finish);

  assign stat.busy     = busy;
  assign stat.idx      = idx;
  assign stat.last_idx = job.last_idx;

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    if (advance) begin
      out_char <= b64e_pkg::sym_char(job.sym[idx]);
      out_last <= finish && job.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (finish) begin
        busy <= 1'b0;
      end else if (advance) begin
        idx <= idx + 2'd1;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/base64_stream_encoder.sv
// top level of the streaming base64 encoder
//
//  channel  signals                               direction
//  input    in_valid, in_stall, data_byte, last_byte   bytes in
//  output   out_valid, out_stall, out_char, out_last   characters out
//
// one byte is taken per cycle while the job queue has room
// characters leave at one per cycle from the back end output register while out_stall is low,
// and an ordinary byte yields one or two characters, a final byte up to four
// a transferred byte passes the queue and the back end job register before its first character is registered
// reset clears the group phase, the queue and the output register
// out_stall holds the output register; the queue absorbs the front end meanwhile
`include "base64_stream_encoder_defines.svh"
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  b64e_pkg::job_t       push_job, head;
  b64e_pkg::back_stat_t bstat;
  logic                 push, pop, q_nonempty, q_full;
  logic [CntW-1:0]      q_count;

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  b64e_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .nonempty (q_nonempty),
    .full     (q_full),
    .count    (q_count)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_nonempty (q_nonempty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_last   (out_last),
    .stat       (bstat)
  );

  `B64E_ASSERT(a_queue_bound, q_count <= CntW'(QUEUE_DEPTH))
  `B64E_ASSERT(a_idx_bound, !bstat.busy || (bstat.idx <= bstat.last_idx))
  `B64E_ASSERT_NEXT(a_transfer_pending, in_valid && !in_stall, (q_count != '0) || bstat.busy)

endmodule

### dv/base64_stream_encoder_tb.sv
// self-checking testbench for the streaming base64 encoder
`timescale 1ns / 1ps
module base64_stream_encoder_tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_BYTES = 250;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } b64_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_last;

  raw_byte_t pending_bytes[$];
  b64_char_t expected_chars[$];

  b64e_pkg::phase_t enc_phase = b64e_pkg::PHASE_FIRST;
  logic [3:0]       enc_left = 4'h0;

  int mismatch_count = 0;
  int idle_cycles = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_tick = 0;
  int stall_mode = 0;
  int sent_bytes = 0;
  int total_bytes = 0;
  raw_byte_t next_byte;
  b64_char_t got_char;
  b64_char_t want_char;

  base64_stream_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] b64_ascii(input logic [5:0] v);
    if (v == 6'd63) begin
      return b64e_pkg::CharSlash;
    end else if (v == 6'd62) begin
      return b64e_pkg::CharPlus;
    end else if (v >= 6'd52) begin
      return b64e_pkg::CharZero + 8'(v - 6'd52);
    end else if (v >= 6'd26) begin
      return b64e_pkg::CharLowerA + 8'(v - 6'd26);
    end
    return b64e_pkg::CharUpperA + 8'(v);
  endfunction

  function automatic void add_char(input logic [7:0] ch, input logic lst);
    b64_char_t c;
    c.ch = ch;
    c.last = lst;
    expected_chars.push_back(c);
  endfunction

  // advance the encoder state by one byte and queue the characters it yields
  task automatic encode_byte(input logic [7:0] b, input logic lst);
    case (enc_phase)
      b64e_pkg::PHASE_SECOND: begin
        add_char(b64_ascii({enc_left[1:0], b[7:4]}), 1'b0);
        if (lst) begin
          add_char(b64_ascii({b[3:0], 2'b00}), 1'b0);
          add_char(b64e_pkg::CharPad, 1'b1);
          enc_phase = b64e_pkg::PHASE_FIRST;
          enc_left = 4'h0;
        end else begin
          enc_left = b[3:0];
          enc_phase = b64e_pkg::PHASE_THIRD;
        end
      end
      b64e_pkg::PHASE_THIRD: begin
        add_char(b64_ascii({enc_left, b[7:6]}), 1'b0);
        add_char(b64_ascii(b[5:0]), lst);
        enc_phase = b64e_pkg::PHASE_FIRST;
        enc_left = 4'h0;
      end
      default: begin
        add_char(b64_ascii(b[7:2]), 1'b0);
        if (lst) begin
          add_char(b64_ascii({b[1:0], 4'h0}), 1'b0);
          add_char(b64e_pkg::CharPad, 1'b0);
          add_char(b64e_pkg::CharPad, 1'b1);
          enc_phase = b64e_pkg::PHASE_FIRST;
          enc_left = 4'h0;
        end else begin
          enc_left = {2'b00, b[1:0]};
          enc_phase = b64e_pkg::PHASE_SECOND;
        end
      end
    endcase
  endtask

  function automatic void queue_byte(input logic [7:0] b, input logic lst);
    raw_byte_t r;
    r.data = b;
    r.last = lst;
    pending_bytes.push_back(r);
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // sender: bursts of transfers separated by random gaps, some of them empty
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_byte(data_byte, last_byte);
        sent_bytes++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          next_byte = pending_bytes.pop_front();
          data_byte <= next_byte.data;
          last_byte <= next_byte.last;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 2) == 0) begin
              gap_left = 0;
            end else if ($urandom_range(0, 9) == 0) begin
              gap_left = $urandom_range(10, 30);
            end else begin
              gap_left = $urandom_range(1, 6);
            end
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, re-chosen at random from four modes
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 64 == 0) begin
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      3: out_stall <= (stall_tick % 3 == 0);
      default: out_stall <= 1'b0;
    endcase
  end

  // check each character transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_char.ch = out_char;
      got_char.last = out_last;
      if (expected_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected char %h last %b", out_char, out_last);
        end
      end else begin
        want_char = expected_chars.pop_front();
        if (got_char !== want_char) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     want_char.ch, want_char.last, got_char.ch, got_char.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout waiting for a transfer");
        $display("base64_stream_encoder_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int count;
    int len;
    // single byte messages, short tails, sign bit and alphabet extremes
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h4D, 1'b0);
    queue_byte(8'h61, 1'b1);
    queue_byte(8'h4D, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h6E, 1'b1);
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'hEF, 1'b0);
    queue_byte(8'hBE, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'h14, 1'b0);
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'h9C, 1'b0);
    queue_byte(8'h03, 1'b0);
    queue_byte(8'hD9, 1'b0);
    queue_byte(8'h7E, 1'b1);

    count = 0;
    while (count < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(10, 24);
      end else begin
        len = $urandom_range(1, 7);
      end
      for (int i = 0; i < len; i++) begin
        queue_byte(random_byte(), i == len - 1);
      end
      count += len;
    end
    total_bytes = pending_bytes.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // wait until every byte has been transferred and predicted
    do begin
      @(posedge clk);
    end while (sent_bytes < total_bytes);
    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("base64_stream_encoder_tb OK");
    end else begin
      $display("base64_stream_encoder_tb NOT OK");
    end
    $finish;
  end

endmodule
